// ----- sv/itl_pkg.sv -----
// Shared types, register codes and radix constants for the integer token lexer.
`timescale 1ns / 1ps

package itl_pkg;

   // Extraction phase of the back end.
   typedef enum logic {
      PHASE_SKIP,
      PHASE_TOKEN
   } phase_type;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_WS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNSIGNED    = 2'd2;

   // Base mode codes.
   localparam logic [1:0] BASE_AUTO = 2'd0;
   localparam logic [1:0] BASE_DEC  = 2'd1;
   localparam logic [1:0] BASE_HEX  = 2'd2;
   localparam logic [1:0] BASE_OCT  = 2'd3;

   // Radix codes as reported on the result.
   localparam logic [4:0] RADIX_AUTO = 5'd0;
   localparam logic [4:0] RADIX_OCT  = 5'd8;
   localparam logic [4:0] RADIX_DEC  = 5'd10;
   localparam logic [4:0] RADIX_HEX  = 5'd16;

   // Digit value of a character that is no hex digit.
   localparam logic [4:0] DIGIT_NONE = 5'd16;

   // Character codes the lexer recognizes.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // Classified character word passed from the front end to the back end.
   typedef struct packed {
      logic       eos;
      logic       space;
      logic       plus;
      logic       minus;
      logic       xchar;
      logic [4:0] digit;
   } class_type;

   // Result word.
   typedef struct packed {
      logic [31:0] value;
      logic        value_written;
      logic        fail;
      logic        eof;
      logic [3:0]  token_length;
      logic [15:0] skipped_count;
      logic [4:0]  radix_used;
   } rsp_type;

   // Radix selected by a base mode code.
   function automatic logic [4:0] mode_radix(input logic [1:0] mode);
      logic [4:0] radix;
      case (mode)
         BASE_DEC: radix = RADIX_DEC;
         BASE_HEX: radix = RADIX_HEX;
         BASE_OCT: radix = RADIX_OCT;
         default:  radix = RADIX_AUTO;
      endcase
      return radix;
   endfunction

endpackage

// ----- sv/itl_fifo.sv -----
// Small register queue with push/pop handshakes, used between the lexer stages.
`timescale 1ns / 1ps

module itl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/itl_front.sv -----
// Front end of the lexer: accepts characters and classifies them into words.
`timescale 1ns / 1ps

module itl_front (
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_ch,
   input  logic                 req_end_of_stream,
   output logic                 class_push,
   output itl_pkg::class_type   class_word,
   input  logic                 class_full
);

   logic is_dec, is_low_hex, is_up_hex;

   // The input side stalls only when the queue to the back end is full.
   assign req_full   = class_full;
   assign class_push = req_push && !class_full;

   assign is_dec     = (req_ch >= itl_pkg::CHAR_ZERO) && (req_ch <= itl_pkg::CHAR_NINE);
   assign is_low_hex = (req_ch >= itl_pkg::CHAR_LOW_A) && (req_ch <= itl_pkg::CHAR_LOW_F);
   assign is_up_hex  = (req_ch >= itl_pkg::CHAR_UP_A) && (req_ch <= itl_pkg::CHAR_UP_F);

   // Character classes do not depend on configuration.
   always_comb begin
      class_word.eos   = req_end_of_stream;
      class_word.space = (req_ch == itl_pkg::CHAR_SPACE) ||
                         ((req_ch >= itl_pkg::CHAR_TAB) && (req_ch <= itl_pkg::CHAR_CR));
      class_word.plus  = (req_ch == itl_pkg::CHAR_PLUS);
      class_word.minus = (req_ch == itl_pkg::CHAR_MINUS);
      class_word.xchar = (req_ch == itl_pkg::CHAR_LOW_X) || (req_ch == itl_pkg::CHAR_UP_X);
      if (is_dec) begin
         class_word.digit = 5'(req_ch - itl_pkg::CHAR_ZERO);
      end else if (is_low_hex) begin
         class_word.digit = 5'(req_ch - itl_pkg::CHAR_LOW_A + 8'd10);
      end else if (is_up_hex) begin
         class_word.digit = 5'(req_ch - itl_pkg::CHAR_UP_A + 8'd10);
      end else begin
         class_word.digit = itl_pkg::DIGIT_NONE;
      end
   end

endmodule

// ----- sv/itl_back.sv -----
// Back end of the lexer: configuration registers, token state machine and accumulator.
`timescale 1ns / 1ps

module itl_back #(
   parameter int BUFFER_SIZE = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [itl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [itl_pkg::CSR_DATA_W-1:0]     csr_data,
   input  itl_pkg::class_type                 class_word,
   input  logic                               class_empty,
   output logic                               class_pop,
   output logic                               rsp_push,
   output itl_pkg::rsp_type                   rsp_word,
   input  logic                               rsp_full
);

   localparam int CW = $clog2(BUFFER_SIZE);

   // Configuration registers.
   logic [1:0] base_ff;
   logic       skip_ff;
   logic       unsigned_ff;

   // Extraction state.
   itl_pkg::phase_type phase_ff, phase_in;
   logic          negative_ff, negative_in;
   logic          sign_seen_ff, sign_seen_in;
   logic [CW-1:0] chars_ff, chars_in;
   logic          have_digit_ff, have_digit_in;
   logic [4:0]    radix_ff, radix_in;
   logic [32:0]   mag_ff, mag_in;
   logic          first_zero_ff, first_zero_in;
   logic [15:0]   space_ff, space_in;

   logic          take;
   logic [4:0]    radix_now;
   logic          prefix_hit, digit_ok, finish, natural_eof, restart;
   logic [CW-1:0] second_pos, first_pos;
   logic [36:0]   mag_wide, product, sum;
   logic          ovf;

   // A word is taken whenever the result queue has room for a possible result.
   assign take      = !class_empty && !rsp_full;
   assign class_pop = take;

   assign second_pos = sign_seen_ff ? CW'(2) : CW'(1);
   assign first_pos  = CW'(sign_seen_ff);
   assign mag_wide   = {4'b0, mag_ff};
   assign radix_now  = (phase_ff == itl_pkg::PHASE_SKIP) ? itl_pkg::mode_radix(base_ff)
                                                         : radix_ff;

   // Next state and result formation.
   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      sign_seen_in  = sign_seen_ff;
      chars_in      = chars_ff;
      have_digit_in = have_digit_ff;
      radix_in      = radix_ff;
      mag_in        = mag_ff;
      first_zero_in = first_zero_ff;
      space_in      = space_ff;
      prefix_hit    = 1'b0;
      digit_ok      = 1'b0;
      finish        = 1'b0;
      natural_eof   = 1'b0;
      restart       = 1'b0;
      ovf           = 1'b0;
      product       = '0;
      sum           = '0;
      rsp_push      = 1'b0;
      rsp_word      = '0;

      if (take) begin
         if ((phase_ff == itl_pkg::PHASE_SKIP) && skip_ff && class_word.eos) begin
            // End of stream while skipping: value is left unwritten.
            rsp_push                = 1'b1;
            rsp_word.value          = '0;
            rsp_word.value_written  = 1'b0;
            rsp_word.fail           = 1'b1;
            rsp_word.eof            = 1'b1;
            rsp_word.token_length   = '0;
            rsp_word.skipped_count  = space_ff;
            rsp_word.radix_used     = itl_pkg::mode_radix(base_ff);
            restart                 = 1'b1;
         end else if ((phase_ff == itl_pkg::PHASE_SKIP) && skip_ff && class_word.space) begin
            if (space_ff != 16'hFFFF) begin
               space_in = space_ff + 1'b1;
            end
         end else begin
            phase_in = itl_pkg::PHASE_TOKEN;
            radix_in = radix_now;
            if (class_word.eos) begin
               finish      = 1'b1;
               natural_eof = 1'b1;
            end else if ((chars_ff == '0) && (class_word.plus || class_word.minus)) begin
               sign_seen_in = 1'b1;
               negative_in  = class_word.minus;
               chars_in     = chars_ff + 1'b1;
               finish       = (chars_in == CW'(BUFFER_SIZE - 1));
            end else begin
               // Prefix handling right after a leading zero.
               if ((chars_ff == second_pos) && first_zero_ff) begin
                  if (class_word.xchar &&
                      ((radix_now == itl_pkg::RADIX_AUTO) || (radix_now == itl_pkg::RADIX_HEX))) begin
                     radix_in      = itl_pkg::RADIX_HEX;
                     have_digit_in = 1'b0;
                     prefix_hit    = 1'b1;
                  end else if (radix_now == itl_pkg::RADIX_AUTO) begin
                     radix_in = itl_pkg::RADIX_OCT;
                  end
               end
               if (radix_in == itl_pkg::RADIX_HEX) begin
                  digit_ok = !class_word.digit[4];
               end else begin
                  digit_ok = (class_word.digit < 5'd10) &&
                             ((radix_in != itl_pkg::RADIX_OCT) || (class_word.digit < 5'd8));
               end
               if (prefix_hit || digit_ok) begin
                  if (!prefix_hit) begin
                     // Shift-add of the running magnitude by the radix in effect.
                     case (radix_in)
                        itl_pkg::RADIX_HEX: product = mag_wide << 4;
                        itl_pkg::RADIX_OCT: product = mag_wide << 3;
                        default:            product = (mag_wide << 3) + (mag_wide << 1);
                     endcase
                     sum = product + 37'(class_word.digit[3:0]);
                     have_digit_in = 1'b1;
                     mag_in = (|sum[36:32]) ? {1'b1, 32'b0} : sum[32:0];
                     if (chars_ff == first_pos) begin
                        first_zero_in = (class_word.digit == 5'd0);
                     end
                  end
                  chars_in = chars_ff + 1'b1;
                  finish   = (chars_in == CW'(BUFFER_SIZE - 1));
               end else begin
                  // A character outside the token ends it and stays in the stream.
                  finish = 1'b1;
               end
            end

            if (finish) begin
               rsp_push               = 1'b1;
               rsp_word.value_written = 1'b1;
               rsp_word.skipped_count = space_ff;
               rsp_word.radix_used    = radix_in;
               if (!have_digit_in) begin
                  rsp_word.value        = '0;
                  rsp_word.fail         = 1'b1;
                  rsp_word.token_length = '0;
                  rsp_word.eof          = natural_eof && (chars_in == '0);
               end else begin
                  rsp_word.token_length = 4'(chars_in);
                  rsp_word.eof          = natural_eof;
                  if (unsigned_ff) begin
                     ovf            = mag_in[32];
                     rsp_word.value = ovf ? 32'hFFFF_FFFF
                                          : (negative_in ? 32'd0 - mag_in[31:0] : mag_in[31:0]);
                  end else if (negative_in) begin
                     ovf            = mag_in[32] || (mag_in[31] && (|mag_in[30:0]));
                     rsp_word.value = ovf ? 32'h8000_0000 : 32'd0 - mag_in[31:0];
                  end else begin
                     ovf            = mag_in[32] || mag_in[31];
                     rsp_word.value = ovf ? 32'h7FFF_FFFF : mag_in[31:0];
                  end
                  rsp_word.fail = ovf;
               end
               restart = 1'b1;
            end
         end

         // Each extraction starts afresh after its result.
         if (restart) begin
            phase_in      = itl_pkg::PHASE_SKIP;
            negative_in   = 1'b0;
            sign_seen_in  = 1'b0;
            chars_in      = '0;
            have_digit_in = 1'b0;
            radix_in      = itl_pkg::mode_radix(base_ff);
            mag_in        = '0;
            first_zero_in = 1'b0;
            space_in      = '0;
         end
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= itl_pkg::BASE_AUTO;
         skip_ff     <= 1'b1;
         unsigned_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            itl_pkg::CSR_BASE_MODE: base_ff     <= csr_data;
            itl_pkg::CSR_SKIP_WS:   skip_ff     <= csr_data[0];
            itl_pkg::CSR_UNSIGNED:  unsigned_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Extraction state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= itl_pkg::PHASE_SKIP;
         negative_ff   <= 1'b0;
         sign_seen_ff  <= 1'b0;
         chars_ff      <= '0;
         have_digit_ff <= 1'b0;
         radix_ff      <= itl_pkg::RADIX_AUTO;
         mag_ff        <= '0;
         first_zero_ff <= 1'b0;
         space_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         sign_seen_ff  <= sign_seen_in;
         chars_ff      <= chars_in;
         have_digit_ff <= have_digit_in;
         radix_ff      <= radix_in;
         mag_ff        <= mag_in;
         first_zero_ff <= first_zero_in;
         space_ff      <= space_in;
      end
   end

endmodule

// ----- sv/integer_token_lexer.sv -----
// Top level of the integer token lexer: front end, word queues and back end.
//
// Usage: characters enter on the req_ channel, one word per cycle, each a
// peeked character or an end-of-stream mark. A word is taken at a rising edge
// with req_push high and req_full low. Results leave on the rsp_ channel: the
// oldest result is on the rsp_ ports while rsp_empty is low and is taken at an
// edge with rsp_pop high. Zero or one result follows each input word; one
// appears when an extraction ends (stop character, end of stream or length cap).
// The stop character itself is not consumed and must be offered again.
// A result enters the result queue as the word that ends the token is taken
// from the character queue. Throughput: one word per cycle while req_full is
// low; the classify in the front end and the shift-add are combinational.
// The csr_ port writes base_mode, skip_whitespace and unsigned_mode; it may be
// written only while the block is idle. Reset clears both queues and starts a
// fresh extraction with auto radix, whitespace skip on and signed conversion.
// When the receiver stalls, the result queue fills, the back end stops taking
// words, and req_full rises once the character queue is full.
`timescale 1ns / 1ps

module integer_token_lexer #(
   parameter int BUFFER_SIZE = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_ch,
   input  logic                             req_end_of_stream,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [31:0]                      rsp_value,
   output logic                             rsp_value_written,
   output logic                             rsp_fail,
   output logic                             rsp_eof,
   output logic [3:0]                       rsp_token_length,
   output logic [15:0]                      rsp_skipped_count,
   output logic [4:0]                       rsp_radix_used,
   input  logic                             csr_write,
   input  logic [itl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [itl_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int QUEUE_DEPTH = 2;
   localparam int CLASS_W     = $bits(itl_pkg::class_type);
   localparam int RSP_W       = $bits(itl_pkg::rsp_type);

   itl_pkg::class_type  class_in_word, class_out_word;
   logic [CLASS_W-1:0]  class_in_bits, class_out_bits;
   logic                class_push, class_full, class_pop, class_empty;
   itl_pkg::rsp_type    rsp_in_word, rsp_out_word;
   logic [RSP_W-1:0]    rsp_in_bits, rsp_out_bits;
   logic                rsp_push, rsp_full;

   assign class_in_bits  = class_in_word;
   assign class_out_word = class_out_bits;
   assign rsp_in_bits    = rsp_in_word;
   assign rsp_out_word   = rsp_out_bits;

   // Character classification.
   itl_front u_front (
      .req_push          (req_push),
      .req_full          (req_full),
      .req_ch            (req_ch),
      .req_end_of_stream (req_end_of_stream),
      .class_push        (class_push),
      .class_word        (class_in_word),
      .class_full        (class_full)
   );

   // Queue of classified words between front and back end.
   itl_fifo #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (class_push),
      .push_data (class_in_bits),
      .full      (class_full),
      .pop       (class_pop),
      .pop_data  (class_out_bits),
      .empty     (class_empty)
   );

   // Token state machine and accumulator.
   itl_back #(
      .BUFFER_SIZE (BUFFER_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .class_word  (class_out_word),
      .class_empty (class_empty),
      .class_pop   (class_pop),
      .rsp_push    (rsp_push),
      .rsp_word    (rsp_in_word),
      .rsp_full    (rsp_full)
   );

   // Result queue toward the receiver.
   itl_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_bits),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_bits),
      .empty     (rsp_empty)
   );

   assign rsp_value         = rsp_out_word.value;
   assign rsp_value_written = rsp_out_word.value_written;
   assign rsp_fail          = rsp_out_word.fail;
   assign rsp_eof           = rsp_out_word.eof;
   assign rsp_token_length  = rsp_out_word.token_length;
   assign rsp_skipped_count = rsp_out_word.skipped_count;
   assign rsp_radix_used    = rsp_out_word.radix_used;

endmodule
